/* hdl/platform_interrupt_controller_defines.svh */
// ----------------------------------------------------------------------------
// Interrupt controller assertion macros
// Shared assertion helpers for the interrupt controller RTL.
// ----------------------------------------------------------------------------
`ifndef PLATFORM_INTERRUPT_CONTROLLER_DEFINES_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PIC_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// implication whose right side is checked in the next cycle
`define PIC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

/* hdl/pic_pkg.sv */
// ----------------------------------------------------------------------------
// Interrupt controller package
// Sizes, request codes and payload types of the interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int NUM_SOURCES  = 32;
    localparam int NUM_CONTEXTS = 2;
    localparam int PRIO_BITS    = 3;
    localparam int ID_BITS      = 5;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_IRQ   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [23:0] addr;
        logic [31:0] wdata;
        logic [4:0]  src_id;
    } pic_req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [1:0]  irq_lines;
        logic        bad_access;
    } pic_rsp_t;

    // best candidate travelling along the scan chain
    typedef struct packed {
        logic                 found;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } pic_cand_t;

endpackage

/* hdl/pic_cell.sv */
// ----------------------------------------------------------------------------
// Interrupt controller source cell
// Holds priority and pending/in-service bits of one source, merges it into
// the best candidate of each context and hands that to the next cell each
// cycle.
// ----------------------------------------------------------------------------
module pic_cell
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  prio_we,
    input  logic [pic_pkg::PRIO_BITS-1:0]         prio_wdata,
    input  logic                                  set_pend,
    input  logic                                  claim,
    input  logic                                  complete,
    input  logic [pic_pkg::NUM_CONTEXTS-1:0]      enable,
    input  logic [pic_pkg::NUM_CONTEXTS-1:0][pic_pkg::PRIO_BITS-1:0] threshold,
    input  logic [pic_pkg::ID_BITS-1:0]           my_id,
    input  pic_pkg::pic_cand_t [pic_pkg::NUM_CONTEXTS-1:0] cand_in,
    output pic_pkg::pic_cand_t [pic_pkg::NUM_CONTEXTS-1:0] cand_out,
    output logic [pic_pkg::PRIO_BITS-1:0]         prio,
    output logic                                  pending
);
    import pic_pkg::*;

    logic [PRIO_BITS-1:0] prio_reg;
    logic                 pend_reg;
    logic                 serv_reg;
    pic_cand_t [NUM_CONTEXTS-1:0] cand_reg;
    pic_cand_t [NUM_CONTEXTS-1:0] cand_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg <= '0;
            pend_reg <= 1'b0;
            serv_reg <= 1'b0;
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (prio_we)
                prio_reg <= prio_wdata;
            if (claim)
            begin
                pend_reg <= 1'b0;
                serv_reg <= 1'b1;
            end
            else if (complete)
                serv_reg <= 1'b0;
            else if (set_pend && !serv_reg)
                pend_reg <= 1'b1;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CONTEXTS; c++)
        begin
            cand_next[c] = cand_in[c];
            if (pend_reg && enable[c] && prio_reg > threshold[c]
                && prio_reg > cand_in[c].prio)
            begin
                cand_next[c].found = 1'b1;
                cand_next[c].id    = my_id;
                cand_next[c].prio  = prio_reg;
            end
        end
    end

    assign cand_out = cand_reg;
    assign prio     = prio_reg;
    assign pending  = pend_reg;

endmodule

/* hdl/platform_interrupt_controller.sv */
// ----------------------------------------------------------------------------
// Platform interrupt controller
//  channel   | signals                  | handshake
//  request   | start, busy, req         | taken when start && !busy
//  response  | rsp_valid, rsp           | one-cycle strobe, no backpressure
// In each pass the best candidate moves one cell per cycle along the row of
// source cells. After the first pass the access commits; the second pass lets
// the new state reach the last cell for the interrupt lines. busy stays high
// from accept through both passes, and the strobe comes in the first cycle
// with busy low, when a new request may already be taken. Reset clears all
// state; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "platform_interrupt_controller_defines.svh"
module platform_interrupt_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pic_pkg::pic_req_t req,
    output logic              rsp_valid,
    output pic_pkg::pic_rsp_t rsp
);
    import pic_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LINES} state_t;

    state_t              state_reg;
    logic [ID_BITS:0]    cnt_reg;
    pic_req_t            req_reg;
    logic                rsp_valid_reg;
    pic_rsp_t            rsp_reg;
    logic [31:0]         rdata_reg;
    logic                bad_reg;

    logic [NUM_CONTEXTS-1:0][NUM_SOURCES-1:0] en_reg;
    logic [NUM_CONTEXTS-1:0][PRIO_BITS-1:0]   thr_reg;

    logic [NUM_SOURCES-1:0]                   prio_we, set_pend, claim_v, compl_v;
    logic [NUM_SOURCES-1:0]                   pend_v;
    logic [NUM_SOURCES-1:0][PRIO_BITS-1:0]    prio_v;
    pic_cand_t [NUM_CONTEXTS-1:0]             chain [NUM_SOURCES+1];
    pic_cand_t [NUM_CONTEXTS-1:0]             best;

    // decoded access
    logic [23:0] a;
    logic        is_wr, is_rd, is_bus;
    logic        dec_prio, dec_pend, dec_en, dec_ctx, dec_bad;
    logic [ID_BITS-1:0] dec_id;
    logic        dec_ctxsel;
    logic        dec_thr, dec_claim;
    logic        cmpl_ok;
    logic [31:0] id_w;

    assign chain[0] = '0;
    assign best     = chain[NUM_SOURCES];

    genvar g;
    generate
        for (g = 0; g < NUM_SOURCES; g++)
        begin : g_cell
            logic [NUM_CONTEXTS-1:0] en_g;
            for (genvar c = 0; c < NUM_CONTEXTS; c++)
            begin : g_en
                assign en_g[c] = en_reg[c][g];
            end
            pic_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .prio_we    (prio_we[g]),
                .prio_wdata (req_reg.wdata[PRIO_BITS-1:0]),
                .set_pend   (set_pend[g]),
                .claim      (claim_v[g]),
                .complete   (compl_v[g]),
                .enable     (en_g),
                .threshold  (thr_reg),
                .my_id      (ID_BITS'(g)),
                .cand_in    (chain[g]),
                .cand_out   (chain[g+1]),
                .prio       (prio_v[g]),
                .pending    (pend_v[g])
            );
        end
    endgenerate

    always_comb
    begin
        a         = {req_reg.addr[23:2], 2'b00};
        is_wr     = req_reg.req_type == REQ_WRITE;
        is_rd     = req_reg.req_type == REQ_READ;
        is_bus    = is_wr || is_rd;
        dec_prio  = a < 24'h001000;
        dec_pend  = !dec_prio && a < 24'h002000;
        dec_en    = !dec_prio && !dec_pend && a < 24'h200000;
        dec_ctx   = a >= 24'h200000;
        dec_id    = a[ID_BITS+1:2];
        dec_ctxsel = 1'b0;
        dec_bad   = 1'b0;
        if (dec_prio)
            dec_bad = a[11:2] == '0 || a[11:2] >= 10'(NUM_SOURCES);
        else if (dec_pend)
            dec_bad = a[11:2] != '0;
        else if (dec_en)
        begin
            dec_ctxsel = a[7];
            dec_bad = a[20:7] >= 14'(NUM_CONTEXTS + 64) || a[6:2] != '0;
        end
        else
        begin
            dec_ctxsel = a[12];
            dec_bad = a[23:12] >= 12'(512 + NUM_CONTEXTS)
                      || (a[11:0] != 12'h000 && a[11:0] != 12'h004);
        end
        dec_thr   = dec_ctx && !dec_bad && a[11:0] == 12'h000;
        dec_claim = dec_ctx && !dec_bad && a[11:0] == 12'h004;
        id_w      = req_reg.wdata;
        cmpl_ok   = id_w != 32'd0 && id_w < 32'(NUM_SOURCES)
                    && en_reg[dec_ctxsel][id_w[ID_BITS-1:0]];
    end

    // commit at the end of the first pass
    logic commit;
    assign commit = state_reg == S_SCAN && cnt_reg == (ID_BITS+1)'(NUM_SOURCES);

    always_comb
    begin
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            prio_we[i]  = commit && is_bus && is_wr && dec_prio && !dec_bad
                          && dec_id == ID_BITS'(i);
            set_pend[i] = commit && req_reg.req_type == REQ_IRQ && i != 0
                          && req_reg.src_id == ID_BITS'(i);
            claim_v[i]  = commit && is_rd && dec_claim && best[dec_ctxsel].found
                          && best[dec_ctxsel].id == ID_BITS'(i);
            compl_v[i]  = commit && is_wr && dec_claim && cmpl_ok
                          && id_w[ID_BITS-1:0] == ID_BITS'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            en_reg        <= '0;
            thr_reg       <= '0;
            req_reg       <= '0;
            rdata_reg     <= '0;
            bad_reg       <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        cnt_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (commit)
                    begin
                        rdata_reg <= '0;
                        bad_reg   <= is_bus && dec_bad;
                        if (is_bus && !dec_bad)
                        begin
                            if (dec_prio && is_rd)
                                rdata_reg <= 32'(prio_v[dec_id]);
                            else if (dec_pend && is_rd)
                                rdata_reg <= 32'(pend_v & ~NUM_SOURCES'(1));
                            else if (dec_en && is_rd)
                                rdata_reg <= 32'(en_reg[dec_ctxsel]);
                            else if (dec_en && is_wr)
                                en_reg[dec_ctxsel] <= req_reg.wdata[NUM_SOURCES-1:0]
                                                      & ~NUM_SOURCES'(1);
                            else if (dec_thr && is_rd)
                                rdata_reg <= 32'(thr_reg[dec_ctxsel]);
                            else if (dec_thr && is_wr)
                                thr_reg[dec_ctxsel] <= req_reg.wdata[PRIO_BITS-1:0];
                            else if (dec_claim && is_rd)
                                rdata_reg <= best[dec_ctxsel].found
                                             ? 32'(best[dec_ctxsel].id) : 32'd0;
                        end
                        cnt_reg   <= '0;
                        state_reg <= S_LINES;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_LINES:
                begin
                    if (cnt_reg == (ID_BITS+1)'(NUM_SOURCES))
                    begin
                        rsp_reg.rdata      <= rdata_reg;
                        rsp_reg.bad_access <= bad_reg;
                        for (int c = 0; c < 2; c++)
                            rsp_reg.irq_lines[c] <= c < NUM_CONTEXTS ? best[c].found
                                                                     : 1'b0;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PIC_ASSERT_IMP(a_claim_onehot, clk, rst_n, 1'b1, $onehot0(claim_v))
    `PIC_ASSERT_IMP(a_valid_idle, clk, rst_n, rsp_valid, state_reg == S_IDLE)
    `PIC_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)

endmodule
